/* rtl/core/sdu_seg_pkg.sv */
// Package for the SDU segmenter / CRC-16 framer: sizes, codes and CRC step.
// No dependencies; used by the interfaces and the top level.
package sdu_seg_pkg;

   localparam int MAX_PDU_BYTES = 254;
   localparam int CHANNELS      = 16;

   localparam int RS_BITS       = 7;
   localparam int RS_PER_REG    = 8;
   localparam int CSR_DATA_W    = RS_BITS * RS_PER_REG;
   localparam int CSR_INDEX_W   = 2;
   localparam int RS_CAP        = (MAX_PDU_BYTES - 3) / 2;
   localparam int LIMIT_BASE    = MAX_PDU_BYTES - 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RS_CH0_TO_7  = 2'd0,
      CSR_RS_CH8_TO_15 = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_CRC_HI  = 2'd1,
      KIND_CRC_LO  = 2'd2
   } byte_kind_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* rtl/core/sdu_seg_if.sv */
// Valid/ready channel interfaces for the SDU segmenter: request, response, CSR write.
// Depends on sdu_seg_pkg.
interface sdu_seg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [3:0] channel;
   logic       sdu_last;
   logic       empty_sdu;

   modport source (output valid, data_byte, channel, sdu_last, empty_sdu, input ready);
   modport sink   (input valid, data_byte, channel, sdu_last, empty_sdu, output ready);
endinterface

interface sdu_seg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] byte_kind;
   logic [3:0] out_channel;
   logic       sdu_end;
   logic [7:0] parity_space;
   logic       last_of_run;

   modport source (output valid, out_byte, byte_kind, out_channel, sdu_end, parity_space,
                   last_of_run, input ready);
   modport sink   (input valid, out_byte, byte_kind, out_channel, sdu_end, parity_space,
                   last_of_run, output ready);
endinterface

interface sdu_seg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sdu_seg_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [sdu_seg_pkg::CSR_DATA_W-1:0]  write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

/* rtl/core/sdu_segmenter_crc16_framer.sv */
// SDU segmenter with CRC-16 framing; depends on sdu_seg_pkg and sdu_seg_if.
// The first response to a request is valid the cycle after acceptance. One request
// per cycle for payload bytes that do not close a segment, while the response side
// is ready; a segment-closing request holds the response register until its byte and
// both CRC bytes are taken (CRC bytes only for an empty SDU). Synchronous active-high
// reset clears CRC/segment state, the RS strength registers and response control flags.
module sdu_segmenter_crc16_framer (
   input logic           clock,
   input logic           reset,
   sdu_seg_req_if.sink   req_bus,
   sdu_seg_rsp_if.source rsp_bus,
   sdu_seg_csr_if.sink   csr_bus
);

   localparam int CDW = sdu_seg_pkg::CSR_DATA_W;

   // configuration
   logic [CDW-1:0] rs_lo_ff, rs_hi_ff;

   // segmenter state
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  fill_ff, fill_in;
   logic [3:0]  held_ch_ff, held_ch_in;
   logic [7:0]  limit_ff, limit_in;
   logic        inside_ff, inside_in;

   // response register
   logic                     rsp_valid_ff;
   sdu_seg_pkg::byte_kind_type code_ff, code_in;
   logic                     crc_follows_ff, crc_follows_in;
   logic [7:0]               pay_ff, pay_in;
   logic [15:0]              run_crc_ff, run_crc_in;
   logic [3:0]               run_ch_ff, run_ch_in;
   logic                     run_end_ff, run_end_in;
   logic [7:0]               run_par_ff, run_par_in;

   logic req_fire, rsp_fire, rsp_last;

   // per-request values
   logic [CDW-1:0] rs_reg;
   logic [6:0]     rs_raw, rs_clamped;
   logic [7:0]     limit_cur, parity_cur, fill_base;
   logic [15:0]    crc_base, crc_next;
   logic [8:0]     fill_next;
   logic           seg_close;

   assign rsp_last = (code_ff == sdu_seg_pkg::KIND_CRC_LO) ||
                     ((code_ff == sdu_seg_pkg::KIND_PAYLOAD) && !crc_follows_ff);
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || (rsp_bus.ready && rsp_last);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // channel's RS strength, clamped
   always_comb begin
      rs_reg = req_bus.channel[3] ? rs_hi_ff : rs_lo_ff;
      rs_raw = rs_reg[req_bus.channel[2:0] * sdu_seg_pkg::RS_BITS +: sdu_seg_pkg::RS_BITS];
      if ({1'b0, req_bus.channel} >= 5'(sdu_seg_pkg::CHANNELS)) begin
         rs_clamped = 7'd0;
      end else if (rs_raw > 7'(sdu_seg_pkg::RS_CAP)) begin
         rs_clamped = 7'(sdu_seg_pkg::RS_CAP);
      end else begin
         rs_clamped = rs_raw;
      end
   end

   always_comb begin
      limit_cur  = inside_ff ? limit_ff : (8'(sdu_seg_pkg::LIMIT_BASE) - {rs_clamped, 1'b0});
      parity_cur = 8'(sdu_seg_pkg::LIMIT_BASE) - limit_cur;
      crc_base   = inside_ff ? crc_ff : sdu_seg_pkg::CRC_INIT;
      fill_base  = inside_ff ? fill_ff : 8'd0;
      held_ch_in = inside_ff ? held_ch_ff : req_bus.channel;
      crc_next   = sdu_seg_pkg::crc16_byte(crc_base, req_bus.data_byte);
      fill_next  = {1'b0, fill_base} + 9'd1;
      seg_close  = req_bus.sdu_last || (fill_next >= {1'b0, limit_cur});

      limit_in = limit_cur;
      pay_in   = req_bus.data_byte;
      run_ch_in  = held_ch_in;
      run_par_in = parity_cur;
      if (req_bus.empty_sdu) begin
         crc_in         = sdu_seg_pkg::CRC_INIT;
         fill_in        = 8'd0;
         inside_in      = 1'b0;
         code_in        = sdu_seg_pkg::KIND_CRC_HI;
         crc_follows_in = 1'b1;
         run_crc_in     = crc_base;
         run_end_in     = 1'b1;
      end else begin
         code_in        = sdu_seg_pkg::KIND_PAYLOAD;
         crc_follows_in = seg_close;
         run_crc_in     = crc_next;
         run_end_in     = req_bus.sdu_last;
         if (seg_close) begin
            crc_in    = sdu_seg_pkg::CRC_INIT;
            fill_in   = 8'd0;
            inside_in = !req_bus.sdu_last;
         end else begin
            crc_in    = crc_next;
            fill_in   = fill_next[7:0];
            inside_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_lo_ff <= '0;
         rs_hi_ff <= '0;
      end else if (csr_bus.valid) begin
         if (csr_bus.reg_index == sdu_seg_pkg::CSR_RS_CH0_TO_7) begin
            rs_lo_ff <= csr_bus.write_data;
         end else if (csr_bus.reg_index == sdu_seg_pkg::CSR_RS_CH8_TO_15) begin
            rs_hi_ff <= csr_bus.write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= sdu_seg_pkg::CRC_INIT;
         fill_ff    <= 8'd0;
         held_ch_ff <= 4'd0;
         limit_ff   <= 8'd0;
         inside_ff  <= 1'b0;
      end else if (req_fire) begin
         crc_ff     <= crc_in;
         fill_ff    <= fill_in;
         held_ch_ff <= held_ch_in;
         limit_ff   <= limit_in;
         inside_ff  <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         code_ff        <= sdu_seg_pkg::KIND_PAYLOAD;
         crc_follows_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff   <= 1'b1;
         code_ff        <= code_in;
         crc_follows_ff <= crc_follows_in;
      end else if (rsp_fire) begin
         if (rsp_last) begin
            rsp_valid_ff <= 1'b0;
         end else if (code_ff == sdu_seg_pkg::KIND_PAYLOAD) begin
            code_ff <= sdu_seg_pkg::KIND_CRC_HI;
         end else begin
            code_ff <= sdu_seg_pkg::KIND_CRC_LO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pay_ff     <= pay_in;
         run_crc_ff <= run_crc_in;
         run_ch_ff  <= run_ch_in;
         run_end_ff <= run_end_in;
         run_par_ff <= run_par_in;
      end
   end

   always_comb begin
      unique case (code_ff)
         sdu_seg_pkg::KIND_CRC_HI: rsp_bus.out_byte = run_crc_ff[15:8];
         sdu_seg_pkg::KIND_CRC_LO: rsp_bus.out_byte = run_crc_ff[7:0];
         default:                  rsp_bus.out_byte = pay_ff;
      endcase
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.byte_kind    = code_ff;
   assign rsp_bus.out_channel  = run_ch_ff;
   assign rsp_bus.sdu_end      = (code_ff == sdu_seg_pkg::KIND_CRC_LO) && run_end_ff;
   assign rsp_bus.parity_space = (code_ff == sdu_seg_pkg::KIND_CRC_LO) ? run_par_ff : 8'd0;
   assign rsp_bus.last_of_run  = rsp_last;

endmodule

/* test/sdu_segmenter_crc16_framer_tb.sv */
// Self-checking testbench for sdu_segmenter_crc16_framer: byte requests in,
// framed segment bytes with CRC-16 out, checked against a local segmenter model.
// Depends on sdu_seg_pkg, the sdu_seg_*_if interfaces and the top level.
module sdu_segmenter_crc16_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [sdu_seg_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [sdu_seg_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;
   localparam int unsigned STALL_LIMIT    = 3000;
   localparam int unsigned BACKLOG_AFTER  = 80;
   localparam int unsigned BACKLOG_CYCLES = 200;
   localparam int unsigned MID_RS         = 100;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] channel;
      logic       sdu_last;
      logic       empty_sdu;
   } sdu_byte_type;

   typedef struct packed {
      logic [7:0]                 out_byte;
      sdu_seg_pkg::byte_kind_type byte_kind;
      logic [3:0]                 out_channel;
      logic                       sdu_end;
      logic [7:0]                 parity_space;
      logic                       last_of_run;
   } framed_byte_type;

   logic clock;
   logic reset;

   sdu_seg_req_if req_ch ();
   sdu_seg_rsp_if rsp_ch ();
   sdu_seg_csr_if csr_ch ();

   sdu_segmenter_crc16_framer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   sdu_byte_type    sdu_bytes_pending[$];
   framed_byte_type frame_bytes_due[$];

   // segmenter model state and register copies
   logic [55:0] rs_lo, rs_hi;
   logic [15:0] seg_crc;
   logic [7:0]  seg_fill, seg_limit, seg_parity;
   logic [3:0]  seg_channel;
   logic        in_sdu;

   int unsigned failures;
   int unsigned items_queued;
   int unsigned requests_taken;
   int unsigned idle_cycles;
   int unsigned req_wait, req_burst, rsp_wait, rsp_burst;
   logic        backlog_forced;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.channel = '0;
      req_ch.sdu_last = 1'b0;
      req_ch.empty_sdu = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.write_data = '0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[15] ^ b[i];
         acc = {acc[14:0], 1'b0} ^ (fb ? sdu_seg_pkg::CRC_POLY : 16'h0000);
      end
      return acc;
   endfunction

   function automatic logic [6:0] clamped_rs(input logic [3:0] ch);
      logic [55:0] word;
      logic [6:0]  rs;
      word = ch[3] ? rs_hi : rs_lo;
      rs   = word[7*ch[2:0] +: 7];
      return (rs > sdu_seg_pkg::RS_CAP) ? 7'(sdu_seg_pkg::RS_CAP) : rs;
   endfunction

   function automatic void push_due(input logic [7:0] b,
                                    input sdu_seg_pkg::byte_kind_type kind,
                                    input logic done, input logic [7:0] parity);
      framed_byte_type f;
      f.out_byte     = b;
      f.byte_kind    = kind;
      f.out_channel  = seg_channel;
      f.sdu_end      = done;
      f.parity_space = parity;
      f.last_of_run  = 1'b0;
      frame_bytes_due.push_back(f);
   endfunction

   function automatic void close_segment(input logic done);
      push_due(seg_crc[15:8], sdu_seg_pkg::KIND_CRC_HI, 1'b0, 8'd0);
      push_due(seg_crc[7:0], sdu_seg_pkg::KIND_CRC_LO, done, seg_parity);
      seg_crc  = sdu_seg_pkg::CRC_INIT;
      seg_fill = 8'd0;
      if (done) in_sdu = 1'b0;
   endfunction

   function automatic void frame_request(input sdu_byte_type r);
      if (!in_sdu) begin
         seg_channel = r.channel;
         seg_parity  = {clamped_rs(r.channel), 1'b0};
         seg_limit   = 8'(sdu_seg_pkg::LIMIT_BASE) - seg_parity;
         seg_crc     = sdu_seg_pkg::CRC_INIT;
         seg_fill    = 8'd0;
         in_sdu      = 1'b1;
      end
      if (r.empty_sdu) begin
         close_segment(1'b1);
      end else begin
         push_due(r.data_byte, sdu_seg_pkg::KIND_PAYLOAD, 1'b0, 8'd0);
         seg_crc  = crc_step(seg_crc, r.data_byte);
         seg_fill = seg_fill + 8'd1;
         if (r.sdu_last || seg_fill >= seg_limit) close_segment(r.sdu_last);
      end
      frame_bytes_due[frame_bytes_due.size()-1].last_of_run = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   // mostly short gaps, a few long ones, and bursts with none
   function automatic int unsigned pick_gap(inout int unsigned burst);
      int unsigned roll;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
         burst = $urandom_range(40, 10);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   function automatic void push_req(input logic [7:0] d, input logic [3:0] ch,
                                    input logic last, input logic empty);
      sdu_byte_type r;
      r.data_byte = d;
      r.channel   = ch;
      r.sdu_last  = last;
      r.empty_sdu = empty;
      sdu_bytes_pending.push_back(r);
      items_queued++;
   endfunction

   // len 0 gives an empty SDU; a breakable SDU may be cut short by an empty marker
   function automatic void queue_sdu(input int unsigned len, input logic breakable);
      logic [3:0] ch;
      ch = 4'($urandom_range(15, 0));
      if (len == 0) begin
         push_req(8'($urandom), ch, $urandom_range(3, 0) != 0, 1'b1);
         return;
      end
      for (int unsigned i = 1; i <= len; i++) begin
         if (breakable && i > 1 && $urandom_range(29, 0) == 0) begin
            push_req(8'($urandom), ch, 1'($urandom_range(1, 0)), 1'b1);
            return;
         end
         push_req(8'($urandom), ch, i == len, 1'b0);
         ch = 4'($urandom_range(15, 0));
      end
   endfunction

   function automatic int unsigned pick_len();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 6) return 0;
      if (roll < 70) return $urandom_range(6, 1);
      if (roll < 95) return $urandom_range(30, 7);
      return $urandom_range(80, 31);
   endfunction

   function automatic void queue_random_sdus(input int unsigned budget);
      int unsigned start;
      start = items_queued;
      while (items_queued - start < budget) queue_sdu(pick_len(), 1'b1);
   endfunction

   function automatic logic [55:0] random_rs_word();
      logic [55:0] w;
      for (int k = 0; k < 8; k++) begin
         case ($urandom_range(3, 0))
            0: w[7*k +: 7] = 7'd0;
            1: w[7*k +: 7] = 7'($urandom_range(127, 120));
            default: w[7*k +: 7] = 7'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic csr_write(input logic [sdu_seg_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sdu_seg_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.reg_index  <= idx;
      csr_ch.write_data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == sdu_seg_pkg::CSR_RS_CH0_TO_7) rs_lo = value;
      else if (idx == sdu_seg_pkg::CSR_RS_CH8_TO_15) rs_hi = value;
   endtask

   task automatic drain();
      do @(posedge clock); while (sdu_bytes_pending.size() != 0 || frame_bytes_due.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            frame_request(sdu_bytes_pending.pop_front());
            requests_taken++;
            req_wait = pick_gap(req_burst);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the offered request
         end else if (req_wait > 0) begin
            req_ch.valid <= 1'b0;
            req_wait--;
         end else if (sdu_bytes_pending.size() != 0) begin
            req_ch.valid     <= 1'b1;
            req_ch.data_byte <= sdu_bytes_pending[0].data_byte;
            req_ch.channel   <= sdu_bytes_pending[0].channel;
            req_ch.sdu_last  <= sdu_bytes_pending[0].sdu_last;
            req_ch.empty_sdu <= sdu_bytes_pending[0].empty_sdu;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!backlog_forced && requests_taken >= BACKLOG_AFTER) begin
            backlog_forced = 1'b1;
            rsp_wait = BACKLOG_CYCLES;
         end
         if (rsp_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_wait = pick_gap(rsp_burst);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      framed_byte_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frame_bytes_due.size() == 0) begin
            $error("response with none expected: byte 0x%0h kind %0d",
                   rsp_ch.out_byte, rsp_ch.byte_kind);
            failures++;
         end else begin
            due = frame_bytes_due.pop_front();
            check_field("out_byte", 16'(due.out_byte), 16'(rsp_ch.out_byte));
            check_field("byte_kind", 16'(due.byte_kind), 16'(rsp_ch.byte_kind));
            check_field("out_channel", 16'(due.out_channel), 16'(rsp_ch.out_channel));
            check_field("sdu_end", 16'(due.sdu_end), 16'(rsp_ch.sdu_end));
            check_field("parity_space", 16'(due.parity_space), 16'(rsp_ch.parity_space));
            check_field("last_of_run", 16'(due.last_of_run), 16'(rsp_ch.last_of_run));
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $error("no handshake for %0d cycles", STALL_LIMIT);
         $display("FAIL sdu_segmenter_crc16_framer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rs_lo          = '0;
      rs_hi          = '0;
      seg_crc        = sdu_seg_pkg::CRC_INIT;
      seg_fill       = '0;
      seg_limit      = '0;
      seg_parity     = '0;
      seg_channel    = '0;
      in_sdu         = 1'b0;
      failures       = 0;
      items_queued   = 0;
      requests_taken = 0;
      idle_cycles    = 0;
      req_wait       = 0;
      req_burst      = 0;
      rsp_wait       = 0;
      rsp_burst      = 0;
      backlog_forced = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ch7..ch0 and ch15..ch8; includes 0, 124, 125 and clamped 126/127
      csr_write(sdu_seg_pkg::CSR_RS_CH0_TO_7,
                {7'd127, 7'd64, 7'd3, 7'd126, 7'd124, 7'd0, 7'd127, 7'd125});
      csr_write(sdu_seg_pkg::CSR_RS_CH8_TO_15,
                {7'd127, 7'd90, 7'd60, 7'd30, 7'd126, 7'd5, 7'd10, 7'd1});
      csr_write(CSR_UNMAPPED_LO, '1);
      csr_write(CSR_UNMAPPED_HI, 56'($urandom));

      push_req(8'h00, 4'd5, 1'b1, 1'b1);    // empty SDU
      push_req(8'hFF, 4'd15, 1'b0, 1'b1);   // empty SDU, last not set
      push_req(8'h00, 4'd0, 1'b0, 1'b0);    // ch0: two-byte segments
      push_req(8'hFF, 4'd0, 1'b0, 1'b0);
      push_req(8'h5A, 4'd3, 1'b1, 1'b0);
      push_req(8'hA5, 4'd0, 1'b0, 1'b0);
      push_req(8'h3C, 4'd0, 1'b1, 1'b0);    // limit and last together
      push_req(8'h80, 4'd1, 1'b0, 1'b0);    // ch1 clamped
      push_req(8'h01, 4'd1, 1'b0, 1'b0);
      push_req(8'hC3, 4'd7, 1'b0, 1'b1);    // empty marker on empty segment
      push_req(8'h12, 4'd3, 1'b0, 1'b0);
      push_req(8'h34, 4'd3, 1'b0, 1'b0);
      push_req(8'hEE, 4'd12, 1'b1, 1'b1);   // empty marker mid-segment
      push_req(8'h7F, 4'd2, 1'b0, 1'b0);    // channel field changes mid-SDU
      push_req(8'hFE, 4'd9, 1'b0, 1'b0);
      push_req(8'h01, 4'd14, 1'b1, 1'b0);
      push_req(8'hAA, 4'd14, 1'b1, 1'b0);
      push_req(8'h55, 4'd8, 1'b0, 1'b0);    // left open across the register change
      push_req(8'h99, 4'd8, 1'b0, 1'b0);
      drain();

      csr_write(sdu_seg_pkg::CSR_RS_CH0_TO_7, '1);
      csr_write(sdu_seg_pkg::CSR_RS_CH8_TO_15, '1);
      push_req(8'h11, 4'd8, 1'b0, 1'b0);
      push_req(8'h22, 4'd0, 1'b0, 1'b0);
      push_req(8'h33, 4'd8, 1'b1, 1'b0);
      queue_random_sdus(30);
      drain();

      csr_write(sdu_seg_pkg::CSR_RS_CH0_TO_7, random_rs_word());
      csr_write(sdu_seg_pkg::CSR_RS_CH8_TO_15, random_rs_word());
      queue_random_sdus(60);
      drain();

      // same mid-range strength everywhere; one SDU runs one byte past a full segment
      csr_write(sdu_seg_pkg::CSR_RS_CH0_TO_7, {8{7'(MID_RS)}});
      csr_write(sdu_seg_pkg::CSR_RS_CH8_TO_15, {8{7'(MID_RS)}});
      queue_random_sdus(10);
      queue_sdu(sdu_seg_pkg::LIMIT_BASE - 2 * MID_RS + 1, 1'b0);
      queue_random_sdus(10);
      drain();

      csr_write(sdu_seg_pkg::CSR_RS_CH0_TO_7, 56'({$urandom, $urandom}));
      csr_write(sdu_seg_pkg::CSR_RS_CH8_TO_15, 56'({$urandom, $urandom}));
      queue_random_sdus(30);
      drain();

      repeat (8) @(posedge clock);
      if (failures == 0 && frame_bytes_due.size() == 0) begin
         $display("PASS sdu_segmenter_crc16_framer");
      end else begin
         $display("FAIL sdu_segmenter_crc16_framer");
      end
      $finish;
   end

endmodule
